FILE: rtl/lphs_pkg.sv
// shared types and constants for the linear probing hash set
`default_nettype none
package lphs_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RESERVED  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_COPY,
        S_WIPE,
        S_RH_RD,
        S_RH_CK,
        S_GO,
        S_PROBE,
        S_DONE
    } state_t;

    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd75;
    localparam int LOAD_SCALE = 100;
    localparam int LIVE_OUT_W = 11;

endpackage
`default_nettype wire

FILE: rtl/lphs_load_check.sv
// load limit check that decides whether an insert doubles the table
`default_nettype none
module lphs_load_check
    import lphs_pkg::*;
#(
    parameter int CNT_W = 11,
    parameter int SL_W  = 4
)
(
    input  wire logic [CNT_W-1:0]   live,
    input  wire logic [LIMIT_W-1:0] limit,
    input  wire logic [SL_W-1:0]    size_log2,
    output logic                    over
);
    localparam int LW = CNT_W + 9;

    logic [LW-1:0] scaled;
    logic [LW-1:0] bound;

    // floor(live*100/size) > limit  <=>  live*100 >= (limit+1)*size
    always_comb
    begin
        scaled = LW'(live) * LW'(LOAD_SCALE);
        bound  = (LW'(limit) + LW'(1)) << size_log2;
        over   = scaled >= bound;
    end
endmodule
`default_nettype wire

FILE: rtl/linear_probe_hash_set.sv
// linear probing hash set top level with sequencer and slot memories
// an item passes decode, go, probe and done, probing on until it resolves; a reserved key or no-op goes decode to done
// doubling copies the table aside, wipes it and reinserts each live key before the insert goes on
// no new item is taken until the result of the last one is registered
// reset: a clearing pass zeroes the slot memory, no item taken meanwhile
// after reset the size is INITIAL_SLOTS capped at MAX_SLOTS, rounded down to a power of two, and the load limit is 75
`default_nettype none
module linear_probe_hash_set
    import lphs_pkg::*;
#(
    parameter int MAX_SLOTS     = 1024,
    parameter int INITIAL_SLOTS = 32,
    parameter int KEY_BITS      = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            opcode,
    input  wire logic [63:0]           key,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 status,
    output logic                       found,
    output logic [LIVE_OUT_W-1:0]      live_count,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [LIMIT_W-1:0]    load_limit_percent
);
    localparam int IDX_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int CP_W       = IDX_W - 1;
    localparam int COPY_DEPTH = MAX_SLOTS / 2;
    localparam int SL_W       = $clog2(IDX_W + 1);
    localparam int INIT_CAP   = (INITIAL_SLOTS < MAX_SLOTS) ? INITIAL_SLOTS : MAX_SLOTS;
    localparam int INIT_LOG2  = $clog2(INIT_CAP + 1) - 1;
    localparam logic [KEY_BITS-1:0] KEY_EMPTY = '0;
    localparam logic [KEY_BITS-1:0] KEY_TOMB  = KEY_BITS'(1);

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [KEY_BITS-1:0]    cur_key_reg, cur_key_next;
    logic                   rehash_reg, rehash_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       pcnt_reg, pcnt_next;
    logic [SL_W-1:0]        size_log2_reg, size_log2_next;
    logic [CNT_W-1:0]       live_reg, live_next;
    logic [LIMIT_W-1:0]     limit_reg;
    status_t                res_status_reg, res_status_next;
    logic                   res_found_reg, res_found_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                status_reg, status_next;
    logic                   found_reg, found_next;
    logic [CNT_W-1:0]       live_out_reg, live_out_next;

    logic [KEY_BITS-1:0]    slot_mem [MAX_SLOTS];
    logic [KEY_BITS-1:0]    slot_rdata_reg;
    logic                   slot_we;
    logic [IDX_W-1:0]       slot_waddr;
    logic [KEY_BITS-1:0]    slot_wdata;
    logic [IDX_W-1:0]       slot_raddr;

    logic [KEY_BITS-1:0]    copy_mem [COPY_DEPTH];
    logic [KEY_BITS-1:0]    copy_rdata_reg;
    logic                   copy_we;
    logic [CP_W-1:0]        copy_waddr;
    logic [CP_W-1:0]        copy_raddr;

    logic [CNT_W-1:0]       size_w;
    logic [IDX_W-1:0]       mask_w;
    logic                   over;
    logic                   can_grow;
    logic                   out_take;
    logic                   in_take;

    lphs_load_check #(
        .CNT_W(CNT_W),
        .SL_W (SL_W)
    ) u_load_check (
        .live     (live_reg),
        .limit    (limit_reg),
        .size_log2(size_log2_reg),
        .over     (over)
    );

    assign size_w    = CNT_W'(1) << size_log2_reg;
    assign mask_w    = IDX_W'(size_w - CNT_W'(1));
    assign can_grow  = size_log2_reg < SL_W'(IDX_W);
    assign in_stall  = state_reg != S_IDLE;
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign live_count = LIVE_OUT_W'(live_out_reg);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (copy_we)
        begin
            copy_mem[copy_waddr] <= slot_rdata_reg;
        end
        copy_rdata_reg <= copy_mem[copy_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            size_log2_reg <= SL_W'(INIT_LOG2);
            live_reg      <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            size_log2_reg <= size_log2_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= load_limit_percent;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        cur_key_reg    <= cur_key_next;
        rehash_reg     <= rehash_next;
        pos_reg        <= pos_next;
        pcnt_reg       <= pcnt_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        live_out_reg   <= live_out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        cur_key_next    = cur_key_reg;
        rehash_next     = rehash_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        pcnt_next       = pcnt_reg;
        size_log2_next  = size_log2_reg;
        live_next       = live_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg && !out_take;
        status_next     = status_reg;
        found_next      = found_reg;
        live_out_next   = live_out_reg;
        slot_we         = 1'b0;
        slot_waddr      = cnt_reg[IDX_W-1:0];
        slot_wdata      = KEY_EMPTY;
        slot_raddr      = cnt_reg[IDX_W-1:0];
        copy_we         = 1'b0;
        copy_waddr      = CP_W'(cnt_reg - CNT_W'(1));
        copy_raddr      = cnt_reg[CP_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we = 1'b1;
                if (cnt_reg == CNT_W'(MAX_SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next    = op_t'(opcode);
                    key_next   = key[KEY_BITS-1:0];
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_status_next = ST_OK;
                res_found_next  = 1'b0;
                cur_key_next    = key_reg;
                rehash_next     = 1'b0;
                cnt_next        = '0;
                if (op_reg == OP_NOP)
                begin
                    state_next = S_DONE;
                end
                else if (key_reg == KEY_EMPTY || key_reg == KEY_TOMB)
                begin
                    res_status_next = ST_RESERVED;
                    state_next      = S_DONE;
                end
                else if (op_reg == OP_INSERT && over && can_grow)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    state_next = S_GO;
                end
            end
            S_COPY:
            begin
                copy_we = cnt_reg != '0;
                if (cnt_reg == size_w)
                begin
                    cnt_next   = '0;
                    state_next = S_WIPE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_WIPE:
            begin
                slot_we = 1'b1;
                if (cnt_reg == size_w - CNT_W'(1))
                begin
                    cnt_next       = '0;
                    size_log2_next = size_log2_reg + SL_W'(1);
                    state_next     = S_RH_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_RH_RD:
            begin
                if (cnt_reg == (size_w >> 1))
                begin
                    cur_key_next = key_reg;
                    rehash_next  = 1'b0;
                    state_next   = S_GO;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_RH_CK;
                end
            end
            S_RH_CK:
            begin
                if (copy_rdata_reg == KEY_EMPTY || copy_rdata_reg == KEY_TOMB)
                begin
                    state_next = S_RH_RD;
                end
                else
                begin
                    cur_key_next = copy_rdata_reg;
                    rehash_next  = 1'b1;
                    state_next   = S_GO;
                end
            end
            S_GO:
            begin
                slot_raddr = cur_key_reg[IDX_W-1:0] & mask_w;
                pos_next   = cur_key_reg[IDX_W-1:0] & mask_w;
                pcnt_next  = '0;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                slot_waddr = pos_reg;
                slot_wdata = cur_key_reg;
                if (rehash_reg && slot_rdata_reg == KEY_EMPTY)
                begin
                    slot_we    = 1'b1;
                    state_next = S_RH_RD;
                end
                else if (!rehash_reg && op_reg == OP_INSERT &&
                         (slot_rdata_reg == KEY_EMPTY || slot_rdata_reg == KEY_TOMB))
                begin
                    slot_we    = 1'b1;
                    live_next  = live_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
                else if (!rehash_reg && op_reg != OP_INSERT &&
                         slot_rdata_reg == cur_key_reg)
                begin
                    if (op_reg == OP_DELETE)
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = KEY_TOMB;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - CNT_W'(1);
                        end
                    end
                    else
                    begin
                        res_found_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else if (!rehash_reg && op_reg != OP_INSERT &&
                         slot_rdata_reg == KEY_EMPTY)
                begin
                    if (op_reg == OP_DELETE)
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else if (pcnt_reg == size_w - CNT_W'(1))
                begin
                    // probe path exhausted
                    if (op_reg == OP_INSERT)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else if (op_reg == OP_DELETE)
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next   = (pos_reg + IDX_W'(1)) & mask_w;
                    slot_raddr = (pos_reg + IDX_W'(1)) & mask_w;
                    pcnt_next  = pcnt_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    found_next     = res_found_reg;
                    live_out_next  = live_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    a_live_fits: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= size_w)
        else $error("live count exceeds table size");

    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        size_log2_reg >= SL_W'(INIT_LOG2) && size_log2_reg <= SL_W'(IDX_W))
        else $error("table size out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("item accepted while previous item in flight");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> status == ST_OK)
        else $error("found with error status");

endmodule
`default_nettype wire

FILE: sim/lphs_checker.sv
// checker for the hash set: predicts results from accepted items and compares them
`timescale 1ns / 1ps
module lphs_checker
    import lphs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [1:0]            opcode,
    input  wire logic [63:0]           key,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [1:0]            status,
    input  wire logic                  found,
    input  wire logic [LIVE_OUT_W-1:0] live_count,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [LIMIT_W-1:0]    load_limit_percent,
    output int                         fail_count,
    output int                         pending,
    output int                         items_seen,
    output int                         doublings
);
    localparam int SLOTS = 1024;

    typedef struct packed {
        status_t                 st;
        logic                    hit;
        logic [LIVE_OUT_W-1:0]   live;
    } answer_t;

    logic [63:0]           table_q [SLOTS];
    logic [63:0]           scratch [SLOTS/2];
    int                    size_q;
    int                    live_q;
    logic [LIMIT_W-1:0]    limit_q;
    answer_t               answers_q [$];

    function automatic int locate(logic [63:0] k);
        int p;
        p = int'(k % size_q);
        for (int i = 0; i < size_q; i++)
        begin
            if (table_q[p] == k)
                return p;
            if (table_q[p] == 64'd0)
                return -1;
            p = (p + 1) % size_q;
        end
        return -1;
    endfunction

    task automatic grow_if_loaded();
        int n;
        int p;
        if ((longint'(live_q) * LOAD_SCALE) / size_q <= limit_q)
            return;
        if (size_q * 2 > SLOTS)
            return;
        for (int i = 0; i < size_q; i++)
            scratch[i] = table_q[i];
        for (int i = 0; i < SLOTS; i++)
            table_q[i] = 64'd0;
        n = size_q * 2;
        for (int i = 0; i < size_q; i++)
        begin
            if (scratch[i] > 64'd1)
            begin
                p = int'(scratch[i] % n);
                for (int j = 0; j < n; j++)
                begin
                    if (table_q[p] == 64'd0)
                    begin
                        table_q[p] = scratch[i];
                        break;
                    end
                    p = (p + 1) % n;
                end
            end
        end
        size_q = n;
        doublings++;
    endtask

    task automatic apply_op(op_t op, logic [63:0] k);
        answer_t a;
        int p;
        bit placed;
        a.st = ST_OK;
        a.hit = 1'b0;
        if (op == OP_NOP)
            ;
        else if (k <= 64'd1)
            a.st = ST_RESERVED;
        else if (op == OP_INSERT)
        begin
            grow_if_loaded();
            p = int'(k % size_q);
            placed = 0;
            for (int i = 0; i < size_q; i++)
            begin
                if (table_q[p] <= 64'd1)
                begin
                    table_q[p] = k;
                    live_q++;
                    placed = 1;
                    break;
                end
                p = (p + 1) % size_q;
            end
            if (!placed)
                a.st = ST_FULL;
        end
        else if (op == OP_DELETE)
        begin
            p = locate(k);
            if (p < 0)
                a.st = ST_NOT_FOUND;
            else
            begin
                table_q[p] = 64'd1;
                if (live_q > 0)
                    live_q--;
            end
        end
        else
            a.hit = (locate(k) >= 0);
        a.live = live_q[LIVE_OUT_W-1:0];
        answers_q.push_back(a);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                table_q[i] = 64'd0;
            size_q = 32;
            live_q = 0;
            limit_q = LIMIT_RESET;
            answers_q.delete();
            fail_count <= 0;
            items_seen = 0;
            doublings = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_q = load_limit_percent;
            if (in_valid && !in_stall)
            begin
                apply_op(op_t'(opcode), key);
                items_seen++;
            end
            if (out_valid && !out_stall)
            begin
                if (answers_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: status %0d found %0d live %0d",
                                 status, found, live_count);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = answers_q.pop_front();
                    if (status !== e.st || found !== e.hit || live_count !== e.live)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp status %0d found %0d live %0d, got %0d %0d %0d",
                                     e.st, e.hit, e.live, status, found, live_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending = answers_q.size();
    end
endmodule

FILE: sim/tb_linear_probe_hash_set.sv
// testbench top: drives items and config writes into the hash set, gives the verdict
`timescale 1ns / 1ps
module tb_linear_probe_hash_set;
    import lphs_pkg::*;

    localparam int WATCHDOG = 1000000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             opcode = OP_NOP;
    logic [63:0]            key = 64'd0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             status;
    logic                   found;
    logic [LIVE_OUT_W-1:0]  live_count;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [LIMIT_W-1:0]     load_limit_percent = LIMIT_RESET;
    int                     fail_count;
    int                     pending;
    int                     items_seen;
    int                     doublings;
    int                     idle_cycles = 0;
    logic [63:0]            used_keys [$];

    always #4 clk = ~clk;

    linear_probe_hash_set dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .key(key),
        .out_valid(out_valid), .out_stall(out_stall), .status(status), .found(found),
        .live_count(live_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .load_limit_percent(load_limit_percent)
    );

    lphs_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .key(key),
        .out_valid(out_valid), .out_stall(out_stall), .status(status), .found(found),
        .live_count(live_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .load_limit_percent(load_limit_percent),
        .fail_count(fail_count), .pending(pending), .items_seen(items_seen),
        .doublings(doublings)
    );

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("watchdog expired, %0d results pending", pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls at random before each result
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            out_stall <= (gap != 0);
            repeat (gap) @(posedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send(op_t op, logic [63:0] k, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        key <= k;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        load_limit_percent <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && used_keys.size() > 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (r < 85)
            return 64'd2 + $urandom_range(0, 3000);
        if (r < 90)
            return 64'($urandom_range(0, 1));
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(int count, int max_gap, int ins_weight);
        op_t op;
        logic [63:0] k;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_weight)
                op = OP_INSERT;
            else if (r < ins_weight + (100 - ins_weight) / 2)
                op = OP_DELETE;
            else if (r < 97)
                op = OP_LOOKUP;
            else
                op = OP_NOP;
            k = pick_key();
            if (op == OP_INSERT && used_keys.size() < 4000)
                used_keys.push_back(k);
            send(op, k, (max_gap == 0 || $urandom_range(0, 3) == 0)
                        ? 0 : $urandom_range(0, max_gap));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_INSERT, 64'd0, 0);
        send(OP_DELETE, 64'd1, 0);
        send(OP_LOOKUP, 64'd1, 0);
        send(OP_DELETE, 64'd77, 0);
        send(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send(OP_INSERT, 64'd2, 1);
        send(OP_INSERT, 64'd34, 0);
        send(OP_INSERT, 64'd34, 0);
        send(OP_LOOKUP, 64'd34, 2);
        send(OP_DELETE, 64'd34, 0);
        send(OP_LOOKUP, 64'd34, 0);
        send(OP_LOOKUP, 64'd66, 0);
        send(OP_INSERT, 64'd66, 0);
        send(OP_NOP, 64'hAAAA_5555_AAAA_5555, 0);
        send(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send(OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send(OP_LOOKUP, 64'h8000_0000_0000_0002, 0);
        settle();

        // extreme limits: fill at limit 99, then 0, 127 and 1, then 50 and 100
        write_limit(7'd99);
        random_phase(150, 18, 80);
        settle();
        write_limit(7'd0);
        random_phase(100, 6, 60);
        settle();
        write_limit(7'd127);
        random_phase(200, 10, 70);
        settle();
        write_limit(7'd1);
        random_phase(300, 0, 60);
        settle();
        write_limit(7'd50);
        random_phase(500, 18, 75);
        settle();
        write_limit(7'd100);
        random_phase(700, 12, 85);
        settle();

        $display("ran %0d items of insert, delete, lookup and no-op with reserved keys",
                 items_seen);
        $display("six load limits exercised, %0d table doublings seen", doublings);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
